// File: rtl/kmpf_pkg.sv
// ----------------------------------------------------------------------------
// kmpf_pkg
// Shared constants, register indexes and types of the stream pattern finder.
// ----------------------------------------------------------------------------
package kmpf_pkg;

    // Longest pattern the cell row can hold, and the width of the offset count.
    localparam int MAX_PATTERN  = 32;
    localparam int OFFSET_WIDTH = 32;

    // Pattern bytes that the configuration words can supply.
    localparam int CFG_WORDS     = 4;
    localparam int CFG_WORD_W    = 64;
    localparam int BYTES_PER_W   = CFG_WORD_W / 8;
    localparam int CFG_BYTES     = CFG_WORDS * BYTES_PER_W;
    localparam int CFG_WORD_IDX_W = (CFG_WORDS > 1) ? $clog2(CFG_WORDS) : 1;

    // Field widths fixed by the interface.
    localparam int BYTE_W        = 8;
    localparam int CFG_LEN_W     = 6;
    localparam int CFG_ADDR_W    = 3;
    localparam int START_W       = 32;

    // Widths derived from the pattern depth.
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_WORD_0 = 3'd1,
        REG_PATTERN_WORD_1 = 3'd2,
        REG_PATTERN_WORD_2 = 3'd3,
        REG_PATTERN_WORD_3 = 3'd4
    } t_cfg_reg;

    // Control that the top level broadcasts to every cell.
    typedef struct packed {
        logic advance;   // a byte is accepted this cycle
        logic kill;      // the byte completes the pattern: drop all progress
        logic flush;     // configuration write: drop all progress
    } t_cell_ctrl;

    // One result item.
    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start;
    } t_result;

endpackage

// File: rtl/kmpf_cell.sv
// ----------------------------------------------------------------------------
// kmpf_cell
// One position of the matcher row: remembers whether the pattern prefix that
// ends at this position matched the stream up to the last byte.
// ----------------------------------------------------------------------------
module kmpf_cell
    import kmpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [BYTE_W-1:0] i_pattern_byte,
    input  logic              i_prev_active,
    output logic              o_hit,
    output logic              o_active
);

    logic r_active;
    logic n_active;

    // The prefix grows by one when the left neighbor was active and the byte fits.
    assign o_hit = i_prev_active && (i_pattern_byte == i_data_byte);

    // Next state of the partial match bit.
    always_comb begin
        n_active = r_active;
        if (i_ctrl.flush) begin
            n_active = 1'b0;
        end else if (i_ctrl.advance) begin
            n_active = o_hit && !i_ctrl.kill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    assign o_active = r_active;

endmodule

// File: rtl/kmpf_out_skid.sv
// ----------------------------------------------------------------------------
// kmpf_out_skid
// Output register with a skid stage, so the input side keeps a registered
// ready while a result waits on the output.
// ----------------------------------------------------------------------------
module kmpf_out_skid
    import kmpf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    n_out_valid;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_out_data;
    t_result n_out_data;
    t_result r_skid_data;
    t_result n_skid_data;
    logic    out_taken;

    assign o_ready   = !r_skid_valid;
    assign out_taken = r_out_valid && i_ready;

    // Move results between the input, the skid stage and the output register.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            if (out_taken) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (i_valid) begin
            if (r_out_valid && !i_ready) begin
                n_skid_valid = 1'b1;
                n_skid_data  = i_data;
            end else begin
                n_out_valid = 1'b1;
                n_out_data  = i_data;
            end
        end else if (out_taken) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

// File: rtl/kmp_stream_pattern_finder.sv
// ----------------------------------------------------------------------------
// kmp_stream_pattern_finder
// Streaming byte pattern matcher with non-overlapping match reports.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Ports                    Contents
//  --------  ---------  -----------------------  -------------------------------
//  s (in)    slave      i_s_tvalid / o_s_tready  tdata: data_byte, tuser: restart
//  m (out)   master     o_m_tvalid / i_m_tready  tdata: match_start, tuser: found
//  cfg       write      i_cfg_we                 i_cfg_addr, i_cfg_wdata
//
//  One byte per cycle while the skid stage is empty. Every cell of the row compares
//  its pattern byte with the incoming byte in the accept cycle; the result is
//  registered in the output register, or in the skid stage if the master stalls.
//  Reset is synchronous and active low; the pattern is one zero byte of length 1.
//  Input ready depends only on the skid stage, so one result can wait while the
//  next request is taken; with the skid full the input stalls.
//
module kmp_stream_pattern_finder
    import kmpf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Stream in
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,    // [7:0] data_byte
    input  logic                  i_s_tuser,    // [0] restart
    // Stream out
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [31:0]           o_m_tdata,    // [31:0] match_start
    output logic                  o_m_tuser,    // [0] match_found
    // Configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_WORD_W-1:0] i_cfg_wdata
);

    logic [CFG_LEN_W-1:0]    r_pattern_length;
    logic [CFG_WORD_W-1:0]   r_pattern_word [CFG_WORDS];
    logic [OFFSET_WIDTH-1:0] r_offset;
    logic [OFFSET_WIDTH-1:0] n_offset;

    logic                    accept;
    logic                    cfg_hit;
    logic [CFG_WORD_IDX_W-1:0] cfg_word_sel;
    logic [LEN_W-1:0]        eff_len;
    logic [IDX_W-1:0]        last_idx;
    logic [OFFSET_WIDTH-1:0] cur_offset;
    logic [OFFSET_WIDTH-1:0] start_full;
    logic                    found;
    logic                    skid_ready;
    t_cell_ctrl              cell_ctrl;
    t_result                 result;
    t_result                 out_data;
    logic [MAX_PATTERN-1:0]  hit;
    logic [MAX_PATTERN-1:0]  active;

    assign o_s_tready = skid_ready;
    assign accept     = i_s_tvalid && skid_ready;

    // Register decode: unknown indexes are ignored.
    always_comb begin
        unique case (i_cfg_addr) inside
            REG_PATTERN_LENGTH, REG_PATTERN_WORD_0, REG_PATTERN_WORD_1,
            REG_PATTERN_WORD_2, REG_PATTERN_WORD_3: cfg_hit = i_cfg_we;
            default:                                cfg_hit = 1'b0;
        endcase
    end

    // Pattern word selected by a word register index.
    assign cfg_word_sel = CFG_WORD_IDX_W'(i_cfg_addr - REG_PATTERN_WORD_0);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= CFG_LEN_W'(1);
            for (int w = 0; w < CFG_WORDS; w++) begin
                r_pattern_word[w] <= '0;
            end
        end else if (cfg_hit) begin
            if (i_cfg_addr == REG_PATTERN_LENGTH) begin
                r_pattern_length <= i_cfg_wdata[CFG_LEN_W-1:0];
            end else begin
                r_pattern_word[cfg_word_sel] <= i_cfg_wdata;
            end
        end
    end

    // Effective pattern length: zero acts as one, the top saturates.
    always_comb begin
        if (r_pattern_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(r_pattern_length) > MAX_PATTERN) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = LEN_W'(r_pattern_length);
        end
    end
    assign last_idx = IDX_W'(eff_len - LEN_W'(1));

    // Broadcast control for the cell row.
    assign found           = accept && hit[last_idx];
    assign cell_ctrl.advance = accept;
    assign cell_ctrl.kill    = found;
    assign cell_ctrl.flush   = cfg_hit;

    // Row of cells; each hands its partial-match bit to its right neighbor.
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        logic [BYTE_W-1:0] pattern_byte;
        logic              prev_active;

        if (j < CFG_BYTES) begin : g_cfg_byte
            assign pattern_byte =
                r_pattern_word[j / BYTES_PER_W][(j % BYTES_PER_W) * BYTE_W +: BYTE_W];
        end else begin : g_zero_byte
            assign pattern_byte = '0;
        end

        if (j == 0) begin : g_head
            assign prev_active = 1'b1;
        end else begin : g_link
            assign prev_active = active[j-1] && !i_s_tuser;
        end

        kmpf_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctrl         (cell_ctrl),
            .i_data_byte    (i_s_tdata),
            .i_pattern_byte (pattern_byte),
            .i_prev_active  (prev_active),
            .o_hit          (hit[j]),
            .o_active       (active[j])
        );
    end

    // Byte offset since the last restart.
    assign cur_offset = i_s_tuser ? '0 : r_offset;
    assign n_offset   = accept ? (cur_offset + OFFSET_WIDTH'(1)) : r_offset;
    assign start_full = cur_offset + OFFSET_WIDTH'(1) - OFFSET_WIDTH'(eff_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else begin
            r_offset <= n_offset;
        end
    end

    // Result item: the start offset is zero when nothing was found.
    assign result.found = found;
    assign result.start = found ? START_W'(start_full) : '0;

    kmpf_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .o_ready (skid_ready),
        .i_data  (result),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (out_data)
    );

    assign o_m_tuser = out_data.found;
    assign o_m_tdata = out_data.start;

endmodule

// File: rtl/kmpf_checker.sv
// ----------------------------------------------------------------------------
// kmpf_checker
// Port-level checks of the stream pattern finder, bound to the top level.
// ----------------------------------------------------------------------------
module kmpf_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [31:0]           o_m_tdata,
    input logic                  o_m_tuser
);

    // A result without a match carries a zero start offset.
    a_zero_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("match_start not zero without a match");

    // An accepted request is always followed, in the next cycle, by a valid result on the output.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> o_m_tvalid)
        else $error("accepted request produced no result");

    // The input stalls only while a result is held on the output.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with an empty output");

    // A result that is not taken stays on the output.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result dropped before it was taken");

endmodule

bind kmp_stream_pattern_finder kmpf_checker u_kmpf_checker (.*);
